>>> design/cau_pkg.sv
package cau_pkg;

  localparam int PortWidth       = 32;
  localparam int DataWidthDefault = 32;
  localparam int FracBitsDefault  = 16;
  localparam int QueueDepth       = 2;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MAG  = 3'd4,
    OP_CONJ = 3'd5,
    OP_EQ   = 3'd6,
    OP_NE   = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0]                  op;
    logic signed [PortWidth-1:0] a_re;
    logic signed [PortWidth-1:0] a_im;
    logic signed [PortWidth-1:0] b_re;
    logic signed [PortWidth-1:0] b_im;
  } in_beat_t;

  typedef struct packed {
    logic signed [PortWidth-1:0] res_re;
    logic signed [PortWidth-1:0] res_im;
    logic                        compare_flag;
    logic                        overflow;
    logic                        div_by_zero;
  } out_beat_t;

  typedef struct packed {
    op_e  op;
    logic is_mul;
    logic is_div;
    logic is_mag;
  } cls_t;

  typedef struct packed {
    cls_t     cls;
    in_beat_t beat;
  } entry_t;

endpackage

>>> design/complex_arithmetic_unit.sv
// Complex ALU on signed fixed point, DATA_WIDTH bits with FRAC_BITS fraction.
// Input channel: in_valid_i / in_stall_o carry one in_beat_t (opcode, a, b).
// Output channel: out_valid_o / out_stall_i carry one out_beat_t per input
// beat, in order: result parts, compare flag, overflow, divide-by-zero.
// Throughput: one beat per cycle on both channels while out_stall_i is low.
// All opcodes take the same path length through the bit-per-stage divider
// pipeline, so results keep their order.
// A two-entry queue sits after the input port; in_stall_o rises only when
// it is full. While out_stall_i holds a waiting result, the whole back
// pipeline freezes and the queue fills, then the input stalls.
// Reset clears the queue and every pipeline valid bit; no clearing pass.
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DataWidthDefault,
  parameter int FRAC_BITS  = cau_pkg::FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cau_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cau_pkg::out_beat_t out_beat_o
);

  cau_pkg::entry_t head;
  logic            head_valid, head_pop;

  cau_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_beat_i,
    .head_valid_o(head_valid),
    .head_pop_i  (head_pop),
    .head_o      (head)
  );

  cau_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i(head_valid),
    .head_pop_o  (head_pop),
    .head_i      (head),
    .out_valid_o,
    .out_stall_i,
    .out_beat_o
  );

endmodule

>>> design/cau_mul.sv
module cau_mul #(
  parameter int DATA_WIDTH = cau_pkg::DataWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [DATA_WIDTH-1:0] a_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  output logic signed [2*DATA_WIDTH-1:0] p_o
);

  localparam int W = DATA_WIDTH;
  localparam int H = (W + 1) / 2;

  logic [2*H-1:0] ua_q, ub_q;
  logic           neg1_q, neg2_q;
  logic [2*H-1:0] ll_q, lh_q, hl_q, hh_q;
  logic [4*H-1:0] sum;
  logic signed [2*W-1:0] p_q;

  logic [W-1:0] ua_d, ub_d;

  assign ua_d = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign ub_d = b_i[W-1] ? W'(-b_i) : W'(b_i);

  assign sum = ({{(2*H){1'b0}}, hh_q} << (2*H))
             + ({{(2*H){1'b0}}, lh_q} << H)
             + ({{(2*H){1'b0}}, hl_q} << H)
             + {{(2*H){1'b0}}, ll_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q   <= (2*H)'(ua_d);
      ub_q   <= (2*H)'(ub_d);
      neg1_q <= a_i[W-1] ^ b_i[W-1];
      ll_q   <= ua_q[H-1:0] * ub_q[H-1:0];
      lh_q   <= ua_q[H-1:0] * ub_q[2*H-1:H];
      hl_q   <= ua_q[2*H-1:H] * ub_q[H-1:0];
      hh_q   <= ua_q[2*H-1:H] * ub_q[2*H-1:H];
      neg2_q <= neg1_q;
      p_q    <= neg2_q ? -$signed(sum[2*W-1:0]) : $signed(sum[2*W-1:0]);
    end
  end

  assign p_o = p_q;

endmodule

>>> design/cau_front.sv
module cau_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cau_pkg::in_beat_t in_beat_i,
  output logic              head_valid_o,
  input  logic              head_pop_i,
  output cau_pkg::entry_t   head_o
);

  localparam int QD   = cau_pkg::QueueDepth;
  localparam int PtrW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CntW = $clog2(QD + 1);

  cau_pkg::entry_t ent_q [QD];
  cau_pkg::entry_t ent_d;
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign in_stall_o   = (cnt_q == CntW'(QD));
  assign head_valid_o = (cnt_q != '0);
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = head_pop_i && head_valid_o;
  assign head_o       = ent_q[rd_q];

  always_comb begin
    ent_d            = '0;
    ent_d.beat       = in_beat_i;
    ent_d.cls.op     = cau_pkg::op_e'(in_beat_i.op);
    ent_d.cls.is_mul = (ent_d.cls.op == cau_pkg::OP_MUL);
    ent_d.cls.is_div = (ent_d.cls.op == cau_pkg::OP_DIV);
    ent_d.cls.is_mag = (ent_d.cls.op == cau_pkg::OP_MAG);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= ent_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(QD - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(QD - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

endmodule

>>> design/cau_back.sv
module cau_back #(
  parameter int DATA_WIDTH = cau_pkg::DataWidthDefault,
  parameter int FRAC_BITS  = cau_pkg::FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  output logic               head_pop_o,
  input  cau_pkg::entry_t    head_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cau_pkg::out_beat_t out_beat_o
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int PW   = 2 * W;
  localparam int SW   = 2 * W + 1;
  localparam int NW   = 2 * W + 1 + F;
  localparam int LAST = NW + 6;
  localparam int PWID = cau_pkg::PortWidth;

  localparam logic signed [W-1:0] MaxV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MinV = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    cau_pkg::cls_t      cls;
    logic signed [W-1:0] re;
    logic signed [W-1:0] im;
    logic               cmp;
    logic               ovf;
    logic               neg_re;
    logic               neg_im;
    logic               dz;
  } ctx_t;

  function automatic logic [W:0] sat_narrow(input logic [W:0] s);
    logic ok;
    ok = (s[W] == s[W-1]);
    if (ok) begin
      return {1'b0, s[W-1:0]};
    end
    return {1'b1, s[W] ? MinV : MaxV};
  endfunction

  function automatic logic signed [W-1:0] from_port(input logic [PWID-1:0] x);
    logic [2*PWID+W-1:0] t;
    t = {{(PWID+W){1'b0}}, x};
    return t[W-1:0];
  endfunction

  function automatic logic [PWID-1:0] to_port(input logic [W-1:0] x);
    logic [PWID+W-1:0] t;
    t = {{PWID{1'b0}}, x};
    return t[PWID-1:0];
  endfunction

  logic en;
  logic [LAST:1] vld_q;

  assign en          = !(out_valid_o && out_stall_i);
  assign head_pop_o  = en && head_valid_i;
  assign out_valid_o = vld_q[LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:1], head_valid_i};
    end
  end

  logic signed [W-1:0] ar, ai, br, bi, sa, sb;
  logic [W:0] s_re, s_im;
  ctx_t ctx0_d, ctx5_d;
  ctx_t ctx_q [1:NW+5];

  assign ar = from_port(head_i.beat.a_re);
  assign ai = from_port(head_i.beat.a_im);
  assign br = from_port(head_i.beat.b_re);
  assign bi = from_port(head_i.beat.b_im);
  assign sa = head_i.cls.is_mag ? ar : br;
  assign sb = head_i.cls.is_mag ? ai : bi;

  always_comb begin
    ctx0_d     = '0;
    ctx0_d.cls = head_i.cls;
    s_re       = '0;
    s_im       = '0;
    unique case (head_i.cls.op)
      cau_pkg::OP_ADD: begin
        s_re = sat_narrow({ar[W-1], ar} + {br[W-1], br});
        s_im = sat_narrow({ai[W-1], ai} + {bi[W-1], bi});
      end
      cau_pkg::OP_SUB: begin
        s_re = sat_narrow({ar[W-1], ar} - {br[W-1], br});
        s_im = sat_narrow({ai[W-1], ai} - {bi[W-1], bi});
      end
      cau_pkg::OP_CONJ: begin
        s_re = {1'b0, ar};
        s_im = sat_narrow(-{ai[W-1], ai});
      end
      cau_pkg::OP_EQ: ctx0_d.cmp = (ar == br) && (ai == bi);
      cau_pkg::OP_NE: ctx0_d.cmp = !((ar == br) && (ai == bi));
      default: ;
    endcase
    ctx0_d.re  = s_re[W-1:0];
    ctx0_d.im  = s_im[W-1:0];
    ctx0_d.ovf = s_re[W] | s_im[W];
  end

  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_s0, p_s1;

  cau_mul #(.DATA_WIDTH(W)) u_mul_rr (.clk_i, .en_i(en), .a_i(ar), .b_i(br), .p_o(p_rr));
  cau_mul #(.DATA_WIDTH(W)) u_mul_ii (.clk_i, .en_i(en), .a_i(ai), .b_i(bi), .p_o(p_ii));
  cau_mul #(.DATA_WIDTH(W)) u_mul_ri (.clk_i, .en_i(en), .a_i(ar), .b_i(bi), .p_o(p_ri));
  cau_mul #(.DATA_WIDTH(W)) u_mul_ir (.clk_i, .en_i(en), .a_i(ai), .b_i(br), .p_o(p_ir));
  cau_mul #(.DATA_WIDTH(W)) u_mul_s0 (.clk_i, .en_i(en), .a_i(sa), .b_i(sa), .p_o(p_s0));
  cau_mul #(.DATA_WIDTH(W)) u_mul_s1 (.clk_i, .en_i(en), .a_i(sb), .b_i(sb), .p_o(p_s1));

  logic signed [SW-1:0] xr_q, xi_q;
  logic [PW-1:0]        dsum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ctx_q[3].cls.is_mul) begin
        xr_q <= SW'(p_rr) - SW'(p_ii);
        xi_q <= SW'(p_ri) + SW'(p_ir);
      end else begin
        xr_q <= SW'(p_rr) + SW'(p_ii);
        xi_q <= SW'(p_ir) - SW'(p_ri);
      end
      dsum_q <= PW'(p_s0) + PW'(p_s1);
    end
  end

  logic signed [SW-1:0] sh_re, sh_im;
  logic [SW-W:0]        top_re, top_im;
  logic                 ok_re, ok_im;
  logic [SW-1:0]        ax_re, ax_im;

  assign sh_re  = xr_q >>> F;
  assign sh_im  = xi_q >>> F;
  assign top_re = sh_re[SW-1:W-1];
  assign top_im = sh_im[SW-1:W-1];
  assign ok_re  = (&top_re) || !(|top_re);
  assign ok_im  = (&top_im) || !(|top_im);
  assign ax_re  = xr_q[SW-1] ? SW'(-xr_q) : SW'(xr_q);
  assign ax_im  = xi_q[SW-1] ? SW'(-xi_q) : SW'(xi_q);

  always_comb begin
    ctx5_d        = ctx_q[4];
    ctx5_d.neg_re = xr_q[SW-1];
    ctx5_d.neg_im = xi_q[SW-1];
    ctx5_d.dz     = (dsum_q == '0);
    if (ctx_q[4].cls.is_mul) begin
      ctx5_d.re  = ok_re ? sh_re[W-1:0] : (sh_re[SW-1] ? MinV : MaxV);
      ctx5_d.im  = ok_im ? sh_im[W-1:0] : (sh_im[SW-1] ? MinV : MaxV);
      ctx5_d.ovf = !ok_re || !ok_im;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q[1] <= ctx0_d;
      ctx_q[2] <= ctx_q[1];
      ctx_q[3] <= ctx_q[2];
      ctx_q[4] <= ctx_q[3];
      ctx_q[5] <= ctx5_d;
      for (int k = 6; k <= NW + 5; k++) begin
        ctx_q[k] <= ctx_q[k-1];
      end
    end
  end

  logic [SW-1:0] rre_q [0:NW];
  logic [SW-1:0] rim_q [0:NW];
  logic [NW-1:0] qre_q [0:NW];
  logic [NW-1:0] qim_q [0:NW];
  logic [PW-1:0] dd_q  [0:NW];
  logic [PW-1:0] sx_q  [0:NW];
  logic [PW-1:0] sr_q  [0:NW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rre_q[0] <= '0;
      rim_q[0] <= '0;
      qre_q[0] <= {ax_re, {F{1'b0}}};
      qim_q[0] <= {ax_im, {F{1'b0}}};
      dd_q[0]  <= dsum_q;
      sx_q[0]  <= dsum_q;
      sr_q[0]  <= '0;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [SW-1:0] t_re, t_im;
    logic [SW:0]   df_re, df_im;
    logic          ge_re, ge_im;

    assign t_re  = {rre_q[k][SW-2:0], qre_q[k][NW-1]};
    assign t_im  = {rim_q[k][SW-2:0], qim_q[k][NW-1]};
    assign df_re = {1'b0, t_re} - {2'b00, dd_q[k]};
    assign df_im = {1'b0, t_im} - {2'b00, dd_q[k]};
    assign ge_re = !df_re[SW];
    assign ge_im = !df_im[SW];

    always_ff @(posedge clk_i) begin
      if (en) begin
        rre_q[k+1] <= ge_re ? df_re[SW-1:0] : t_re;
        rim_q[k+1] <= ge_im ? df_im[SW-1:0] : t_im;
        qre_q[k+1] <= {qre_q[k][NW-2:0], ge_re};
        qim_q[k+1] <= {qim_q[k][NW-2:0], ge_im};
        dd_q[k+1]  <= dd_q[k];
      end
    end

    if (k < W) begin : g_sqrt
      localparam logic [PW-1:0] One = {{(PW-1){1'b0}}, 1'b1} << (2 * (W - 1 - k));
      logic [PW:0] tr;
      logic        take;

      assign tr   = {1'b0, sr_q[k]} + {1'b0, One};
      assign take = ({1'b0, sx_q[k]} >= tr);

      always_ff @(posedge clk_i) begin
        if (en) begin
          sx_q[k+1] <= take ? PW'({1'b0, sx_q[k]} - tr) : sx_q[k];
          sr_q[k+1] <= take ? (sr_q[k] >> 1) + One : sr_q[k] >> 1;
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        if (en) begin
          sx_q[k+1] <= sx_q[k];
          sr_q[k+1] <= sr_q[k];
        end
      end
    end
  end

  localparam logic [NW-1:0] LimPos = NW'(MaxV);
  localparam logic [NW-1:0] LimNeg = NW'(MaxV) + 1'b1;

  ctx_t                ctx_f;
  logic [NW-1:0]       q_re, q_im;
  logic                qo_re, qo_im, mo;
  logic signed [W-1:0] qv_re, qv_im;
  logic [W-1:0]        root;
  cau_pkg::out_beat_t  beat_d, beat_q;

  assign ctx_f = ctx_q[NW+5];
  assign q_re  = qre_q[NW];
  assign q_im  = qim_q[NW];
  assign root  = sr_q[NW][W-1:0];
  assign qo_re = ctx_f.neg_re ? (q_re > LimNeg) : (q_re > LimPos);
  assign qo_im = ctx_f.neg_im ? (q_im > LimNeg) : (q_im > LimPos);
  assign qv_re = qo_re ? (ctx_f.neg_re ? MinV : MaxV)
                       : (ctx_f.neg_re ? -$signed(q_re[W-1:0]) : $signed(q_re[W-1:0]));
  assign qv_im = qo_im ? (ctx_f.neg_im ? MinV : MaxV)
                       : (ctx_f.neg_im ? -$signed(q_im[W-1:0]) : $signed(q_im[W-1:0]));
  assign mo    = root > MaxV;

  always_comb begin
    beat_d              = '0;
    beat_d.compare_flag = ctx_f.cmp;
    if (ctx_f.cls.is_div) begin
      if (ctx_f.dz) begin
        beat_d.div_by_zero = 1'b1;
      end else begin
        beat_d.res_re   = to_port(qv_re);
        beat_d.res_im   = to_port(qv_im);
        beat_d.overflow = qo_re | qo_im;
      end
    end else if (ctx_f.cls.is_mag) begin
      beat_d.res_re   = to_port(mo ? MaxV : root);
      beat_d.overflow = mo;
    end else begin
      beat_d.res_re   = to_port(ctx_f.re);
      beat_d.res_im   = to_port(ctx_f.im);
      beat_d.overflow = ctx_f.ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      beat_q <= beat_d;
    end
  end

  assign out_beat_o = beat_q;

endmodule

>>> design/cau_checker.sv
module cau_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input cau_pkg::out_beat_t out_beat_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_beat_o))
    else $error("result beat changed while stalled");

  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.div_by_zero |->
      out_beat_o.res_re == '0 && out_beat_o.res_im == '0 &&
      !out_beat_o.overflow && !out_beat_o.compare_flag)
    else $error("divide-by-zero beat carries data");

  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.compare_flag |->
      out_beat_o.res_re == '0 && out_beat_o.res_im == '0 && !out_beat_o.overflow)
    else $error("compare beat carries data");

  a_hs_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_stall_o, out_valid_o}))
    else $error("handshake output unknown");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

>>> dv/complex_arithmetic_unit_checker.sv
module complex_arithmetic_unit_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  cau_pkg::in_beat_t  in_beat_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  cau_pkg::out_beat_t out_beat_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int Frac = cau_pkg::FracBitsDefault;
  localparam logic signed [127:0] QMax = 128'sd2147483647;
  localparam logic signed [127:0] QMin = -128'sd2147483648;

  cau_pkg::out_beat_t result_fifo[$];

  function automatic logic [32:0] saturate(input logic signed [127:0] v);
    if (v > QMax) return {1'b1, 32'h7fff_ffff};
    if (v < QMin) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic signed [127:0] fx_div(input logic signed [127:0] n,
                                                input logic signed [127:0] d);
    logic [127:0] mag;
    logic [127:0] q;
    mag = n[127] ? -n : n;
    q = (mag << Frac) / d;
    return n[127] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic cau_pkg::out_beat_t complex_result(input cau_pkg::in_beat_t x);
    cau_pkg::out_beat_t o;
    logic signed [127:0] ar, ai, br, bi, d;
    logic [32:0] sr, si;
    ar = x.a_re;
    ai = x.a_im;
    br = x.b_re;
    bi = x.b_im;
    o = '0;
    sr = '0;
    si = '0;
    unique case (cau_pkg::op_e'(x.op))
      cau_pkg::OP_ADD: begin
        sr = saturate(ar + br);
        si = saturate(ai + bi);
      end
      cau_pkg::OP_SUB: begin
        sr = saturate(ar - br);
        si = saturate(ai - bi);
      end
      cau_pkg::OP_MUL: begin
        sr = saturate((ar * br - ai * bi) >>> Frac);
        si = saturate((ar * bi + ai * br) >>> Frac);
      end
      cau_pkg::OP_DIV: begin
        d = br * br + bi * bi;
        if (d == 0) begin
          o.div_by_zero = 1'b1;
        end else begin
          sr = saturate(fx_div(ar * br + ai * bi, d));
          si = saturate(fx_div(ai * br - ar * bi, d));
        end
      end
      cau_pkg::OP_MAG: begin
        sr = saturate($signed(floor_sqrt(ar * ar + ai * ai)));
      end
      cau_pkg::OP_CONJ: begin
        sr = saturate(ar);
        si = saturate(-ai);
      end
      cau_pkg::OP_EQ: o.compare_flag = (ar == br) && (ai == bi);
      default: o.compare_flag = !((ar == br) && (ai == bi));
    endcase
    o.res_re = sr[31:0];
    o.res_im = si[31:0];
    o.overflow = sr[32] | si[32];
    return o;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    cau_pkg::out_beat_t exp_b;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (result_fifo.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o++;
        end else begin
          exp_b = result_fifo.pop_front();
          flag_field("res_re", exp_b.res_re, out_beat_i.res_re);
          flag_field("res_im", exp_b.res_im, out_beat_i.res_im);
          flag_field("compare_flag", exp_b.compare_flag, out_beat_i.compare_flag);
          flag_field("overflow", exp_b.overflow, out_beat_i.overflow);
          flag_field("div_by_zero", exp_b.div_by_zero, out_beat_i.div_by_zero);
        end
      end
      if (in_valid_i && !in_stall_i) result_fifo.push_back(complex_result(in_beat_i));
      pending_o = result_fifo.size();
    end
  end
endmodule

>>> dv/complex_arithmetic_unit_tb.sv
module complex_arithmetic_unit_tb;

  localparam int IdleLimit = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  cau_pkg::in_beat_t  in_beat = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  cau_pkg::out_beat_t out_beat;
  int        fail_count;
  int        pending;
  int        idle_cycles = 0;
  int        rx_wait = 0;
  logic      rx_quiet = 1'b0;
  logic      tx_quiet = 1'b0;
  int        op_count[8];

  complex_arithmetic_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  complex_arithmetic_unit_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_beat_i  (out_beat),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (out_valid && !out_stall) begin
      if ($urandom_range(0, 15) == 0) rx_quiet <= !rx_quiet;
      rx_wait <= rx_quiet ? 0 : $urandom_range(0, 11);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
    end
  end

  always @(negedge clk_i) out_stall <= rst_ni && (rx_wait != 0);

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_beat(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat <= '{op: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
    op_count[op]++;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 32'hfffff) - 32'h80000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'd0;
      4: return $urandom_range(0, 32'h3ffffff) - 32'h2000000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] v[6];
    logic [31:0] ar, ai, br, bi;
    logic [2:0] op;
    v = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0001_0000, 32'hffff_0000};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < 8; k++) begin
      send_beat(k[2:0], v[1], v[2], v[1], v[2]);
      send_beat(k[2:0], v[2], v[2], v[2], v[1]);
      send_beat(k[2:0], v[4], v[5], v[0], v[0]);
    end
    send_beat(cau_pkg::OP_DIV, v[3], v[1], v[3], v[0]);

    // hold until the pipeline drains
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);

    for (int n = 0; n < 1300; n++) begin
      op = 3'($urandom_range(0, 7));
      ar = pick_value();
      ai = pick_value();
      br = pick_value();
      bi = pick_value();
      case ($urandom_range(0, 7))
        0: {br, bi} = {ar, ai};
        1: bi = ai;
        2: if (op == cau_pkg::OP_DIV) {br, bi} = '0;
        default: ;
      endcase
      send_beat(op, ar, ai, br, bi);
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (150) @(posedge clk_i);
    $display("covered %0d add, %0d sub, %0d mul, %0d div beats", op_count[0], op_count[1],
             op_count[2], op_count[3]);
    $display("and %0d magnitude, %0d conjugate, %0d equal, %0d not-equal beats", op_count[4],
             op_count[5], op_count[6], op_count[7]);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
